FILE: src/fnrs_pkg.sv
package fnrs_pkg;

  localparam int PATCH_SLOTS = 32;
  localparam int PATCH_BYTES = 30;
  localparam int SLOT_W      = (PATCH_SLOTS > 1) ? $clog2(PATCH_SLOTS) : 1;
  localparam int MEM_DEPTH   = PATCH_SLOTS * PATCH_BYTES;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int PC_W        = 6;
  localparam int NUM_CH      = 6;

  // command codes
  localparam logic [2:0] OP_NOTE_ON     = 3'd0;
  localparam logic [2:0] OP_KEY_RELEASE = 3'd1;
  localparam logic [2:0] OP_PATCH_WR    = 3'd2;
  localparam logic [2:0] OP_RAW         = 3'd3;
  localparam logic [2:0] OP_SILENCE     = 3'd4;

  // chip registers
  localparam logic [7:0] REG_KEY    = 8'h28;
  localparam logic [7:0] REG_DAC    = 8'h2B;
  localparam logic [7:0] REG_OP     = 8'h30;
  localparam logic [7:0] REG_FLO    = 8'hA0;
  localparam logic [7:0] REG_FHI    = 8'hA4;
  localparam logic [7:0] REG_FB_ALG = 8'hB0;
  localparam logic [7:0] REG_PAN    = 8'hB4;

  // patch byte positions
  localparam logic [4:0] IDX_FB_ALG = 5'd28;
  localparam logic [4:0] IDX_PAN    = 5'd29;

  // default patch values
  localparam logic [7:0] DEF_TL  = 8'h7F;
  localparam logic [7:0] DEF_RR  = 8'hFF;
  localparam logic [7:0] DEF_PAN = 8'hC0;

  localparam logic [10:0] FNUM [12] = '{
    11'd617, 11'd653, 11'd692, 11'd733, 11'd777, 11'd823,
    11'd872, 11'd924, 11'd979, 11'd1037, 11'd1099, 11'd1164
  };

  localparam logic [7:0] SLOT_OFF [4] = '{8'h00, 8'h08, 8'h04, 8'h0C};

  // program addresses
  localparam logic [PC_W-1:0] PC_DISPATCH = 6'd0;
  localparam logic [PC_W-1:0] PC_NOTE     = 6'd1;
  localparam int              PC_OPS      = 3;
  localparam logic [PC_W-1:0] PC_FREQ     = 6'd31;
  localparam logic [PC_W-1:0] PC_KEY_OFF  = 6'd34;
  localparam logic [PC_W-1:0] PC_RAW      = 6'd35;
  localparam logic [PC_W-1:0] PC_SILENCE  = 6'd36;
  localparam logic [PC_W-1:0] PC_PATCH_WR = 6'd43;
  localparam logic [PC_W-1:0] PC_FILL     = 6'd44;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] channel;
    logic [7:0] note;
    logic [7:0] instrument;
    logic [4:0] patch_slot;
    logic [4:0] patch_index;
    logic [7:0] patch_byte;
    logic [8:0] raw_address;
    logic [7:0] raw_value;
  } cmd_t;

  typedef struct packed {
    logic       port;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    SQ_NEXT, SQ_END, SQ_DISPATCH, SQ_ROW, SQ_FILL
  } seq_t;

  typedef enum logic [1:0] {PS_CH, PS_ZERO, PS_RAW} port_sel_t;
  typedef enum logic [1:0] {AS_CONST, AS_CH, AS_RAW} addr_sel_t;
  typedef enum logic [2:0] {
    DS_CONST, DS_MEM, DS_FNUM_LO, DS_FNUM_HI, DS_KEY_ON, DS_KEY_OFF, DS_RAW
  } data_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_BYTE, WR_FILL} wr_sel_t;

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  typedef struct packed {
    seq_t       seq;
    logic       emit;
    logic       last;
    port_sel_t  port_sel;
    addr_sel_t  addr_sel;
    logic [7:0] addr_base;
    data_sel_t  data_sel;
    logic [7:0] data_const;
    logic [4:0] rd_idx;
    wr_sel_t    wr;
    logic       clr_rows;
  } ucode_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ch_ok;
    logic       inst_ok;
    logic       pw_ok;
    logic       row_ok;
    logic       fill_last;
  } status_t;

  localparam ucode_t UC_NOP = '{
    seq: SQ_END, emit: 1'b0, last: 1'b0, port_sel: PS_ZERO, addr_sel: AS_CONST,
    addr_base: 8'h00, data_sel: DS_CONST, data_const: 8'h00, rd_idx: 5'd0,
    wr: WR_NONE, clr_rows: 1'b0
  };

  function automatic logic [7:0] default_byte(input logic [4:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      5'd1, 5'd8, 5'd15, 5'd22:  b = DEF_TL;
      5'd5, 5'd12, 5'd19, 5'd26: b = DEF_RR;
      IDX_PAN:                   b = DEF_PAN;
      default:                   b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [ADDR_W-1:0] patch_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [4:0] idx);
    return ADDR_W'(slot) * ADDR_W'(PATCH_BYTES) + ADDR_W'(idx);
  endfunction

  function automatic logic [SLOT_W-1:0] to_slot(input logic [7:0] v);
    return v[SLOT_W-1:0];
  endfunction

  // control program
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    int k;
    w = UC_NOP;
    unique case (pc)
      PC_DISPATCH: begin
        w.seq = SQ_DISPATCH; w.rd_idx = IDX_FB_ALG;
      end
      PC_NOTE: begin
        w.seq = SQ_NEXT; w.emit = 1'b1; w.port_sel = PS_CH; w.addr_sel = AS_CH;
        w.addr_base = REG_FB_ALG; w.data_sel = DS_MEM; w.rd_idx = IDX_PAN;
      end
      6'd2: begin
        w.seq = SQ_NEXT; w.emit = 1'b1; w.port_sel = PS_CH; w.addr_sel = AS_CH;
        w.addr_base = REG_PAN; w.data_sel = DS_MEM; w.rd_idx = 5'd0;
      end
      PC_FREQ: begin
        w.seq = SQ_NEXT; w.emit = 1'b1; w.port_sel = PS_CH; w.addr_sel = AS_CH;
        w.addr_base = REG_FLO; w.data_sel = DS_FNUM_LO;
      end
      6'd32: begin
        w.seq = SQ_NEXT; w.emit = 1'b1; w.port_sel = PS_CH; w.addr_sel = AS_CH;
        w.addr_base = REG_FHI; w.data_sel = DS_FNUM_HI;
      end
      6'd33: begin
        w.emit = 1'b1; w.last = 1'b1; w.addr_base = REG_KEY; w.data_sel = DS_KEY_ON;
      end
      PC_KEY_OFF: begin
        w.emit = 1'b1; w.last = 1'b1; w.addr_base = REG_KEY; w.data_sel = DS_KEY_OFF;
      end
      PC_RAW: begin
        w.emit = 1'b1; w.last = 1'b1; w.port_sel = PS_RAW; w.addr_sel = AS_RAW;
        w.data_sel = DS_RAW;
      end
      PC_SILENCE: begin
        w.seq = SQ_NEXT; w.emit = 1'b1; w.addr_base = REG_DAC; w.data_const = 8'h00;
      end
      6'd37, 6'd38, 6'd39, 6'd40, 6'd41: begin
        w.seq = SQ_NEXT; w.emit = 1'b1; w.addr_base = REG_KEY;
        w.data_const = (pc >= 6'd40) ? 8'(pc - 6'd36) : 8'(pc - 6'd37);
      end
      6'd42: begin
        w.emit = 1'b1; w.last = 1'b1; w.addr_base = REG_KEY; w.data_const = 8'h06;
        w.clr_rows = 1'b1;
      end
      PC_PATCH_WR: begin
        w.seq = SQ_ROW; w.wr = WR_BYTE;
      end
      PC_FILL: begin
        w.seq = SQ_FILL; w.wr = WR_FILL;
      end
      default: w = UC_NOP;
    endcase
    // operator writes in slot order 0,8,4,C
    for (int o = 0; o < 4; o++) begin
      for (int f = 0; f < 7; f++) begin
        k = o * 7 + f;
        if (pc == PC_W'(PC_OPS + k)) begin
          w = UC_NOP;
          w.seq       = SQ_NEXT;
          w.emit      = 1'b1;
          w.port_sel  = PS_CH;
          w.addr_sel  = AS_CH;
          w.addr_base = 8'(REG_OP + 8'(f * 16) + SLOT_OFF[o]);
          w.data_sel  = DS_MEM;
          w.rd_idx    = 5'(k + 1);
        end
      end
    end
    return w;
  endfunction

endpackage

FILE: src/fnrs_ram.sv
module fnrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 960
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/fnrs_seq.sv
module fnrs_seq
  import fnrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t stat,
  output logic    busy,
  output ucode_t  uc
);

  seq_state_t      state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic            finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      pc    <= PC_DISPATCH;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    finish     = 1'b0;
    uc         = (state == SEQ_RUN) ? ucode(pc) : UC_NOP;
    if (state == SEQ_RUN) begin
      unique case (uc.seq)
        SQ_NEXT: pc_next = pc + PC_W'(1);
        SQ_END:  finish = 1'b1;
        SQ_DISPATCH: begin
          priority case (stat.op)
            OP_NOTE_ON: begin
              if (!stat.ch_ok) finish = 1'b1;
              else pc_next = stat.inst_ok ? PC_NOTE : PC_FREQ;
            end
            OP_KEY_RELEASE: begin
              if (stat.ch_ok) pc_next = PC_KEY_OFF;
              else finish = 1'b1;
            end
            OP_PATCH_WR: begin
              if (stat.pw_ok) pc_next = PC_PATCH_WR;
              else finish = 1'b1;
            end
            OP_RAW:     pc_next = PC_RAW;
            OP_SILENCE: pc_next = PC_SILENCE;
            default:    finish = 1'b1;
          endcase
        end
        // slot already live: single byte write, else fill the row
        SQ_ROW: begin
          if (stat.row_ok) finish = 1'b1;
          else pc_next = PC_FILL;
        end
        SQ_FILL: begin
          if (stat.fill_last) finish = 1'b1;
        end
        default: finish = 1'b1;
      endcase
    end
    busy = (state == SEQ_RUN) && !finish;
    if (start && !busy) begin
      state_next = SEQ_RUN;
      pc_next    = PC_DISPATCH;
    end else if (finish) begin
      state_next = SEQ_IDLE;
    end
  end

endmodule

FILE: src/fnrs_datapath.sv
module fnrs_datapath
  import fnrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  cmd_t    cmd,
  input  ucode_t  uc,
  output status_t stat,
  output logic    strobe,
  output result_t result
);

  cmd_t              held;
  logic [PATCH_SLOTS-1:0] row_valid;
  logic [4:0]        fill_idx;
  logic [2:0]        blk;
  logic [10:0]       fnum;
  logic              rd_valid;
  logic [7:0]        rd_def;
  logic [7:0]        ram_q;
  logic [7:0]        mem_byte;

  logic [SLOT_W-1:0] rslot, wslot;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              hi;
  logic [1:0]        c;
  logic [2:0]        k;
  logic [20:0]       ge;
  logic [4:0]        q;
  logic [7:0]        rem;
  result_t           res_next;

  assign rslot = to_slot(held.instrument);
  assign wslot = to_slot({3'b000, held.patch_slot});
  assign hi    = held.channel >= 8'd3;
  assign c     = hi ? 2'(held.channel[2:0] - 3'd3) : held.channel[1:0];
  assign k     = hi ? held.channel[2:0] + 3'd1 : held.channel[2:0];

  always_comb begin
    stat.op        = held.op;
    stat.ch_ok     = held.channel < 8'(NUM_CH);
    stat.inst_ok   = {1'b0, held.instrument} < 9'(PATCH_SLOTS);
    stat.pw_ok     = ({4'b0000, held.patch_slot} < 9'(PATCH_SLOTS))
                     && (held.patch_index < 5'(PATCH_BYTES));
    stat.row_ok    = row_valid[wslot];
    stat.fill_last = fill_idx == 5'(PATCH_BYTES - 1);
  end

  // octave and semitone of the held note
  always_comb begin
    for (int t = 1; t <= 21; t++) begin
      ge[t-1] = held.note >= 8'(12 * t);
    end
    q   = 5'($countones(ge));
    rem = held.note - 8'({3'b000, q} * 8'd12);
  end

  always_ff @(posedge clk) begin
    blk  <= (q > 5'd7) ? 3'd7 : q[2:0];
    fnum <= FNUM[rem[3:0]];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= cmd;
    end
  end

  // patch memory writes
  always_comb begin
    we    = 1'b0;
    waddr = patch_addr(wslot, held.patch_index);
    wdata = held.patch_byte;
    unique case (uc.wr)
      WR_BYTE: we = stat.row_ok;
      WR_FILL: begin
        we    = 1'b1;
        waddr = patch_addr(wslot, fill_idx);
        wdata = (fill_idx == held.patch_index) ? held.patch_byte
                                               : default_byte(fill_idx);
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (uc.clr_rows) begin
      row_valid <= '0;
    end else if (uc.wr == WR_FILL && stat.fill_last) begin
      row_valid[wslot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.wr == WR_FILL) begin
      fill_idx <= fill_idx + 5'd1;
    end else begin
      fill_idx <= 5'd0;
    end
  end

  fnrs_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (patch_addr(rslot, uc.rd_idx)),
    .rdata (ram_q)
  );

  // an unwritten slot reads as the default patch
  always_ff @(posedge clk) begin
    rd_valid <= row_valid[rslot];
    rd_def   <= default_byte(uc.rd_idx);
  end

  assign mem_byte = rd_valid ? ram_q : rd_def;

  always_comb begin
    res_next.last = uc.last;
    unique case (uc.port_sel)
      PS_CH:   res_next.port = hi;
      PS_RAW:  res_next.port = held.raw_address[8];
      default: res_next.port = 1'b0;
    endcase
    unique case (uc.addr_sel)
      AS_CH:   res_next.reg_addr = uc.addr_base + {6'b000000, c};
      AS_RAW:  res_next.reg_addr = held.raw_address[7:0];
      default: res_next.reg_addr = uc.addr_base;
    endcase
    unique case (uc.data_sel)
      DS_MEM:     res_next.reg_data = mem_byte;
      DS_FNUM_LO: res_next.reg_data = fnum[7:0];
      DS_FNUM_HI: res_next.reg_data = {2'b00, blk, fnum[10:8]};
      DS_KEY_ON:  res_next.reg_data = {5'b11110, k};
      DS_KEY_OFF: res_next.reg_data = {5'b00000, k};
      DS_RAW:     res_next.reg_data = held.raw_value;
      default:    res_next.reg_data = uc.data_const;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= uc.emit;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

FILE: src/fm_note_register_sequencer.sv
// an accepted command first runs a dispatch step; each emitting step's write is
// registered onto strobe and result. throughput: one step of the control program per
// cycle; note_on writes the patch only for an instrument in range; patch_write writes
// one byte, or fills the row on the first write to a slot since reset or silence_all;
// an ignored command ends at dispatch; writes leave one per cycle and cannot be held off
// reset clears the sequencer and marks every patch slot as default; no sweep is needed
module fm_note_register_sequencer
  import fnrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  ucode_t  uc;
  status_t stat;
  logic    accept;

  assign accept = start && !busy;

  fnrs_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .uc    (uc)
  );

  fnrs_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .uc     (uc),
    .stat   (stat),
    .strobe (strobe),
    .result (result)
  );

  // writes of one command leave back to back until the final one
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("gap inside a write sequence");

  // the sequencer only releases busy on a final write or a silent step
  a_release: assert property (@(posedge clk) disable iff (rst)
    !busy && uc.emit |-> uc.last)
    else $error("busy released before the final write");

  // the final step of a program shows up as the last transfer
  a_last: assert property (@(posedge clk) disable iff (rst)
    uc.emit && uc.last |=> strobe && result.last)
    else $error("final write not flagged");

endmodule

FILE: test/tb_fm_note_register_sequencer.sv
// predicts the register writes of the note sequencer and checks them in order
class write_sequence_model;
  localparam logic [7:0] KEY_REG    = 8'h28;
  localparam logic [7:0] DAC_REG    = 8'h2B;
  localparam logic [7:0] OPER_REG   = 8'h30;
  localparam logic [7:0] FLO_REG    = 8'hA0;
  localparam logic [7:0] FHI_REG    = 8'hA4;
  localparam logic [7:0] FB_ALG_REG = 8'hB0;
  localparam logic [7:0] PAN_REG    = 8'hB4;
  localparam int         NUM_BYTES  = 30;

  logic [7:0] patches [fnrs_pkg::PATCH_SLOTS][NUM_BYTES];
  fnrs_pkg::result_t expected_writes [$];
  fnrs_pkg::result_t cmd_writes [$];
  int fail_count;
  int reported;

  function new();
    fail_count = 0;
    reported   = 0;
    restore_defaults();
  endfunction

  function void restore_defaults();
    for (int s = 0; s < fnrs_pkg::PATCH_SLOTS; s++) begin
      for (int b = 0; b < NUM_BYTES; b++) patches[s][b] = 8'h00;
      for (int o = 0; o < 4; o++) begin
        patches[s][o * 7 + 1] = 8'h7F;
        patches[s][o * 7 + 5] = 8'hFF;
      end
      patches[s][29] = 8'hC0;
    end
  endfunction

  function void add_write(logic p, logic [7:0] a, logic [7:0] d);
    fnrs_pkg::result_t w;
    w.port     = p;
    w.reg_addr = a;
    w.reg_data = d;
    w.last     = 1'b0;
    cmd_writes.push_back(w);
  endfunction

  function logic [10:0] fnum_of(logic [3:0] semitone);
    logic [10:0] f;
    case (semitone)
      4'd0:    f = 11'd617;
      4'd1:    f = 11'd653;
      4'd2:    f = 11'd692;
      4'd3:    f = 11'd733;
      4'd4:    f = 11'd777;
      4'd5:    f = 11'd823;
      4'd6:    f = 11'd872;
      4'd7:    f = 11'd924;
      4'd8:    f = 11'd979;
      4'd9:    f = 11'd1037;
      4'd10:   f = 11'd1099;
      default: f = 11'd1164;
    endcase
    return f;
  endfunction

  function void accept_command(fnrs_pkg::cmd_t c);
    logic              hi;
    logic [7:0]        lane;
    logic [2:0]        key_sel;
    logic [10:0]       fnum;
    logic [2:0]        octave;
    logic [7:0]        slot_ofs;
    fnrs_pkg::result_t w;
    cmd_writes.delete();
    hi      = (c.channel >= 8'd3);
    lane    = hi ? c.channel - 8'd3 : c.channel;
    key_sel = hi ? 3'(c.channel + 8'd1) : 3'(c.channel);
    case (c.op)
      fnrs_pkg::OP_NOTE_ON: begin
        if (c.channel < 8'd6) begin
          fnum   = fnum_of(4'(c.note % 8'd12));
          octave = (c.note >= 8'd96) ? 3'd7 : 3'(c.note / 8'd12);
          if (int'(c.instrument) < fnrs_pkg::PATCH_SLOTS) begin
            add_write(hi, FB_ALG_REG + lane, patches[c.instrument][28]);
            add_write(hi, PAN_REG + lane, patches[c.instrument][29]);
            for (int o = 0; o < 4; o++) begin
              // operator slots go 0, 8, 4, C
              case (o)
                0:       slot_ofs = 8'h00;
                1:       slot_ofs = 8'h08;
                2:       slot_ofs = 8'h04;
                default: slot_ofs = 8'h0C;
              endcase
              for (int f = 0; f < 7; f++)
                add_write(hi, OPER_REG + 8'(f * 16) + slot_ofs + lane,
                          patches[c.instrument][o * 7 + f]);
            end
          end
          add_write(hi, FLO_REG + lane, fnum[7:0]);
          add_write(hi, FHI_REG + lane, {2'b00, octave, fnum[10:8]});
          add_write(1'b0, KEY_REG, {5'b11110, key_sel});
        end
      end
      fnrs_pkg::OP_KEY_RELEASE: begin
        if (c.channel < 8'd6) add_write(1'b0, KEY_REG, {5'b00000, key_sel});
      end
      fnrs_pkg::OP_PATCH_WR: begin
        if (c.patch_index < 5'd30 && int'(c.patch_slot) < fnrs_pkg::PATCH_SLOTS)
          patches[c.patch_slot][c.patch_index] = c.patch_byte;
      end
      fnrs_pkg::OP_RAW: begin
        add_write(c.raw_address[8], c.raw_address[7:0], c.raw_value);
      end
      fnrs_pkg::OP_SILENCE: begin
        add_write(1'b0, DAC_REG, 8'h00);
        for (int i = 0; i < 6; i++) add_write(1'b0, KEY_REG, 8'((i >= 3) ? i + 1 : i));
        restore_defaults();
      end
      default: ;
    endcase
    if (cmd_writes.size() > 0) begin
      w = cmd_writes[cmd_writes.size() - 1];
      w.last = 1'b1;
      cmd_writes[cmd_writes.size() - 1] = w;
    end
    foreach (cmd_writes[i]) expected_writes.push_back(cmd_writes[i]);
  endfunction

  function void check_write(fnrs_pkg::result_t got);
    fnrs_pkg::result_t want;
    if (expected_writes.size() == 0) begin
      fail_count++;
      if (reported < 10)
        $display("unexpected write: port %0d addr %02h data %02h last %0d",
                 got.port, got.reg_addr, got.reg_data, got.last);
      reported++;
      return;
    end
    want = expected_writes.pop_front();
    if (got.port !== want.port || got.reg_addr !== want.reg_addr ||
        got.reg_data !== want.reg_data || got.last !== want.last) begin
      fail_count++;
      if (reported < 10)
        $display("write mismatch: expected port %0d addr %02h data %02h last %0d,",
                 want.port, want.reg_addr, want.reg_data, want.last,
                 " got port %0d addr %02h data %02h last %0d",
                 got.port, got.reg_addr, got.reg_data, got.last);
      reported++;
    end
  endfunction

  function int pending();
    return expected_writes.size();
  endfunction
endclass

module tb_fm_note_register_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import fnrs_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 105;

  // op codes the block does not define
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    strobe;
  result_t result;

  write_sequence_model model;
  int cycle_count = 0;
  int burst_left  = 4;
  int effective_items;

  always #10 clk = ~clk;

  fm_note_register_sequencer i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // every strobed write is a transfer; the receiver cannot hold it off
  always @(posedge clk) begin
    if (!rst && strobe) model.check_write(result);
  end

  function automatic bit has_effect(cmd_t c);
    case (c.op)
      OP_NOTE_ON, OP_KEY_RELEASE: return c.channel < 8'd6;
      OP_PATCH_WR:                return c.patch_index < 5'd30;
      OP_RAW, OP_SILENCE:         return 1'b1;
      default:                    return 1'b0;
    endcase
  endfunction

  function automatic cmd_t random_fields();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(cmd_t)-1:0];
  endfunction

  function automatic cmd_t make_op(logic [2:0] code);
    cmd_t c;
    c = '0;
    c.op = code;
    return c;
  endfunction

  function automatic cmd_t make_note_on(logic [7:0] ch, logic [7:0] nt, logic [7:0] inst);
    cmd_t c;
    c = make_op(OP_NOTE_ON);
    c.channel    = ch;
    c.note       = nt;
    c.instrument = inst;
    return c;
  endfunction

  function automatic cmd_t make_key_release(logic [7:0] ch);
    cmd_t c;
    c = make_op(OP_KEY_RELEASE);
    c.channel = ch;
    return c;
  endfunction

  function automatic cmd_t make_patch(logic [4:0] slot, logic [4:0] idx, logic [7:0] val);
    cmd_t c;
    c = make_op(OP_PATCH_WR);
    c.patch_slot  = slot;
    c.patch_index = idx;
    c.patch_byte  = val;
    return c;
  endfunction

  function automatic cmd_t make_raw(logic [8:0] addr, logic [7:0] val);
    cmd_t c;
    c = make_op(OP_RAW);
    c.raw_address = addr;
    c.raw_value   = val;
    return c;
  endfunction

  function automatic cmd_t random_item();
    cmd_t c;
    int   pick;
    c    = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      c.op = OP_NOTE_ON;
      if ($urandom_range(0, 6) != 0) c.channel = 8'($urandom_range(0, 5));
      if ($urandom_range(0, 4) != 0) c.instrument = 8'($urandom_range(0, 31));
    end else if (pick < 45) begin
      c.op = OP_KEY_RELEASE;
      if ($urandom_range(0, 6) != 0) c.channel = 8'($urandom_range(0, 5));
    end else if (pick < 65) begin
      c.op = OP_PATCH_WR;
      if ($urandom_range(0, 9) != 0) c.patch_index = 5'($urandom_range(0, 29));
    end else if (pick < 85) begin
      c.op = OP_RAW;
    end else if (pick < 90) begin
      c.op = OP_SILENCE;
    end else if (pick < 95) begin
      case ($urandom_range(0, 2))
        0:       c.op = OP_SPARE_A;
        1:       c.op = OP_SPARE_B;
        default: c.op = OP_SPARE_C;
      endcase
    end
    // otherwise the op stays fully random
    return c;
  endfunction

  // holds the command until the transfer, start stays high for a following one
  task automatic issue(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    model.accept_command(c);
  endtask

  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  task automatic send(input cmd_t c);
    issue(c);
    if (has_effect(c)) effective_items++;
    pace();
  endtask

  // load a few bytes into one slot, then play a note with it and sometimes release the key
  task automatic program_and_play();
    cmd_t c;
    int   slot;
    int   ch;
    slot = $urandom_range(0, 31);
    ch   = $urandom_range(0, 5);
    repeat ($urandom_range(1, 8)) begin
      c = random_fields();
      c.op          = OP_PATCH_WR;
      c.patch_slot  = 5'(slot);
      c.patch_index = 5'($urandom_range(0, 29));
      send(c);
    end
    c = random_fields();
    c.op         = OP_NOTE_ON;
    c.channel    = 8'(ch);
    c.instrument = 8'(slot);
    send(c);
    if ($urandom_range(0, 1) != 0) begin
      c = random_fields();
      c.op      = OP_KEY_RELEASE;
      c.channel = 8'(ch);
      send(c);
    end
  endtask

  initial begin
    model = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send(make_note_on(8'd0, 8'd0, 8'd0));
    send(make_raw(9'h1FF, 8'hFF));
    send(make_raw(9'h000, 8'h00));
    send(make_patch(5'd31, 5'd0, 8'hA5));
    send(make_patch(5'd31, 5'd28, 8'h07));
    send(make_patch(5'd31, 5'd29, 8'h3C));
    send(make_patch(5'd31, 5'd27, 8'hFF));
    send(make_patch(5'd31, 5'd30, 8'h11));
    send(make_patch(5'd31, 5'd31, 8'h22));
    send(make_note_on(8'd5, 8'd255, 8'd31));
    send(make_note_on(8'd3, 8'd95, 8'd200));
    send(make_note_on(8'd2, 8'd11, 8'd32));
    send(make_note_on(8'd6, 8'd60, 8'd0));
    send(make_note_on(8'd255, 8'd60, 8'd0));
    send(make_key_release(8'd0));
    send(make_key_release(8'd5));
    send(make_key_release(8'd6));
    send(make_op(OP_SPARE_A));
    send(make_op(OP_SPARE_B));
    send(make_op(OP_SPARE_C));
    send(make_op(OP_SILENCE));
    send(make_note_on(8'd4, 8'd60, 8'd31));
    send(make_patch(5'd0, 5'd0, 8'h00));
    send(make_note_on(8'd1, 8'd127, 8'd0));

    effective_items = 0;
    while (effective_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 4) program_and_play();
      else send(random_item());
    end
    start <= 1'b0;

    while (model.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (model.fail_count == 0 && model.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
